>>> rtl/ssno_pkg.sv
// Package: shared constants, register codes, config struct and segment table.
package ssno_pkg;

    localparam int DIGITS = 4;

    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int PIX_W    = 8;
    localparam int NUM_W    = 14;
    localparam int LEN_W    = 6;
    localparam int PITCH_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int GEO_W    = 13;
    localparam int DIG_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // n / 10 == (n * RECIP10) >> RECIP_SHIFT for every 14-bit n
    localparam logic [12:0] RECIP10     = 13'd6554;
    localparam int          RECIP_SHIFT = 16;
    localparam int          PROD_W      = NUM_W + 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHOWN_NUMBER = 3'd0,
        REG_ANCHOR_ROW   = 3'd1,
        REG_ANCHOR_COL   = 3'd2,
        REG_SEG_LEN      = 3'd3,
        REG_DIGIT_PITCH  = 3'd4,
        REG_INK          = 3'd5
    } reg_index_t;

    localparam logic [ROW_W-1:0]   ANCHOR_ROW_RST  = 10'd440;
    localparam logic [COL_W-1:0]   ANCHOR_COL_RST  = 10'd560;
    localparam logic [LEN_W-1:0]   SEG_LEN_RST     = 6'd10;
    localparam logic [PITCH_W-1:0] DIGIT_PITCH_RST = 7'd20;
    localparam logic [PIX_W-1:0]   INK_RST         = 8'd255;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint unsigned NUM_LIMIT = pow10(DIGITS) - 1;

    typedef logic [6:0] seg_mask_t;

    // bit s lights segment a..g
    function automatic seg_mask_t seg_decode(input logic [3:0] digit);
        seg_mask_t m;
        case (digit)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic [ROW_W-1:0]             anchor_row;
        logic [COL_W-1:0]             anchor_col;
        logic [LEN_W-1:0]             seg_len;
        logic [PITCH_W-1:0]           digit_pitch;
        logic [PIX_W-1:0]             ink;
        logic [DIGITS-1:0][6:0]       masks;
    } cfg_t;

endpackage

>>> rtl/ssno_if.sv
// Interfaces: pixel input channel and pixel result channel.
interface ssno_pix_if
    import ssno_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] pix_row;
    logic [COL_W-1:0] pix_col;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pix_row, output pix_col, output pixel_in,
                    input ready);
    modport sink   (input valid, input pix_row, input pix_col, input pixel_in,
                    output ready);
endinterface

interface ssno_res_if
    import ssno_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

>>> rtl/ssno_cfg.sv
// Configuration registers and serial decimal digit decoder.
module ssno_cfg
    import ssno_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  busy
);

    logic [ROW_W-1:0]       anchor_row_reg;
    logic [COL_W-1:0]       anchor_col_reg;
    logic [LEN_W-1:0]       seg_len_reg;
    logic [PITCH_W-1:0]     digit_pitch_reg;
    logic [PIX_W-1:0]       ink_reg;
    logic [DIGITS-1:0][6:0] masks_reg;

    logic                   busy_reg, busy_next;
    logic [NUM_W-1:0]       conv_n_reg, conv_n_next;
    logic [DIG_IDX_W-1:0]   conv_k_reg, conv_k_next;

    logic [PROD_W-1:0]      prod;
    logic [NUM_W-1:0]       quot;
    logic [NUM_W-1:0]       quot10;
    logic [3:0]             rem;
    seg_mask_t              digit_mask;
    logic [NUM_W-1:0]       num_sat;
    logic                   num_wr;

    assign num_wr  = cfg_we && (cfg_index == REG_SHOWN_NUMBER);
    assign num_sat = (64'(cfg_data) > NUM_LIMIT) ? NUM_W'(NUM_LIMIT) : cfg_data;

    assign prod       = PROD_W'(conv_n_reg) * PROD_W'(RECIP10);
    assign quot       = NUM_W'(prod >> RECIP_SHIFT);
    assign quot10     = (quot << 3) + (quot << 1);
    assign rem        = 4'(conv_n_reg - quot10);
    assign digit_mask = (conv_n_reg != '0) ? seg_decode(rem) : '0;

    always_comb
    begin
        busy_next   = busy_reg;
        conv_n_next = conv_n_reg;
        conv_k_next = conv_k_reg;
        if (num_wr)
        begin
            busy_next   = 1'b1;
            conv_n_next = num_sat;
            conv_k_next = '0;
        end
        else if (busy_reg)
        begin
            conv_n_next = quot;
            conv_k_next = conv_k_reg + 1'b1;
            if (conv_k_reg == DIG_IDX_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_row_reg  <= ANCHOR_ROW_RST;
            anchor_col_reg  <= ANCHOR_COL_RST;
            seg_len_reg     <= SEG_LEN_RST;
            digit_pitch_reg <= DIGIT_PITCH_RST;
            ink_reg         <= INK_RST;
            masks_reg       <= '0;
            busy_reg        <= 1'b0;
            conv_n_reg      <= '0;
            conv_k_reg      <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            conv_n_reg <= conv_n_next;
            conv_k_reg <= conv_k_next;
            if (busy_reg && !num_wr)
            begin
                masks_reg[conv_k_reg] <= digit_mask;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ANCHOR_ROW:  anchor_row_reg  <= cfg_data[ROW_W-1:0];
                    REG_ANCHOR_COL:  anchor_col_reg  <= cfg_data[COL_W-1:0];
                    REG_SEG_LEN:     seg_len_reg     <= cfg_data[LEN_W-1:0];
                    REG_DIGIT_PITCH: digit_pitch_reg <= cfg_data[PITCH_W-1:0];
                    REG_INK:         ink_reg         <= cfg_data[PIX_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // zero length draws as one
    assign cfg.seg_len     = (seg_len_reg == '0) ? LEN_W'(1) : seg_len_reg;
    assign cfg.anchor_row  = anchor_row_reg;
    assign cfg.anchor_col  = anchor_col_reg;
    assign cfg.digit_pitch = digit_pitch_reg;
    assign cfg.ink         = ink_reg;
    assign cfg.masks       = masks_reg;
    assign busy            = busy_reg;

endmodule

>>> rtl/ssno_hit.sv
// Segment hit test of one pixel against all digit cells.
module ssno_hit
    import ssno_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    output logic             hit
);

    logic signed [GEO_W-1:0] r, c, len, top, mid, bot;
    logic [DIGITS-1:0]       digit_hit;

    assign r   = GEO_W'(row);
    assign c   = GEO_W'(col);
    assign len = GEO_W'(cfg.seg_len);
    assign top = GEO_W'(cfg.anchor_row);
    assign mid = top + len;
    assign bot = mid + len;

    for (genvar g = 0; g < DIGITS; g++)
    begin : g_digit
        logic signed [GEO_W-1:0] off, left, right;
        logic                    on_top, on_mid, on_bot, on_left, on_right;
        logic                    in_cols, in_upper, in_lower;
        logic [6:0]              m;

        assign off   = GEO_W'(g) * GEO_W'(cfg.digit_pitch);
        assign left  = GEO_W'(cfg.anchor_col) - off;
        assign right = left + len;
        assign m     = cfg.masks[g];

        assign on_top   = (r == top);
        assign on_mid   = (r == mid);
        assign on_bot   = (r == bot);
        assign on_left  = (c == left);
        assign on_right = (c == right);
        assign in_cols  = (c >= left) && (c <= right);
        assign in_upper = (r >= top) && (r <= mid);
        assign in_lower = (r >= mid) && (r <= bot);

        assign digit_hit[g] = (m[0] && on_top && in_cols)
                            || (m[1] && on_right && in_upper)
                            || (m[2] && on_right && in_lower)
                            || (m[3] && on_bot && in_cols)
                            || (m[4] && on_left && in_lower)
                            || (m[5] && on_left && in_upper)
                            || (m[6] && on_mid && in_cols);
    end

    assign hit = |digit_hit;

endmodule

>>> rtl/seven_segment_number_overlay.sv
// Top level: seven-segment number overlay on a pixel stream.
// Pixels enter on the pix channel (valid/ready) with their row and column;
// each yields one transaction on the res channel carrying pixel_out, which
// is the ink value on a lit segment of the shown number, else pixel_in.
// The pixel path is an input register, the segment hit test, and a result
// register, whose valid flag is res.valid; one pixel is accepted every
// cycle while the receiver keeps up and the digit decoder is idle.
// When res.ready is low the result register holds and the input register
// may still take one more pixel; pix.ready drops when both are full or busy.
// Registers are written through cfg_we/cfg_index/cfg_data. Writing
// shown_number starts the digit decoder, which resolves one decimal digit
// per cycle: pix.ready stays low until all DIGITS digits are resolved.
// Reset returns all registers to their defaults (number zero, nothing
// drawn) and empties the pipeline.
module seven_segment_number_overlay
    import ssno_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ssno_pix_if.sink              pix,
    ssno_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg;
    logic             busy;
    logic             hit;
    logic             advance;
    logic             accept;

    logic             s1_valid_reg, s1_valid_next;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s2_valid_reg, s2_valid_next;
    logic [PIX_W-1:0] s2_pix_reg;

    ssno_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy)
    );

    ssno_hit u_hit (
        .cfg (cfg),
        .row (s1_row_reg),
        .col (s1_col_reg),
        .hit (hit)
    );

    assign advance   = !s2_valid_reg || res.ready;
    assign pix.ready = !busy && (!s1_valid_reg || advance);
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = s1_valid_reg;
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg <= pix.pix_row;
            s1_col_reg <= pix.pix_col;
            s1_pix_reg <= pix.pixel_in;
        end
        if (advance)
        begin
            s2_pix_reg <= hit ? cfg.ink : s1_pix_reg;
        end
    end

    assign res.valid     = s2_valid_reg;
    assign res.pixel_out = s2_pix_reg;

endmodule

>>> bench/tb_seven_segment_number_overlay.sv
// Testbench: seven-segment number overlay checked pixel by pixel against a predictor, random stalls.
module tb_seven_segment_number_overlay
    import ssno_pkg::*;
();

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 9;
    localparam int PHASE_PIXELS  = 55;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // segments a..g on bits 0..6
    localparam seg_mask_t DIGIT_SEGMENTS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_PIXEL,
        STEP_KNOWN
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [PIX_W-1:0]      pixel;
        logic [PIX_W-1:0]      known;
    } step_t;

    localparam int DIRECTED_STEPS = 43;
    localparam step_t DIRECTED [DIRECTED_STEPS] = '{
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd440,  10'd560,  8'h12, 8'h12},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd1023, 10'd1023, 8'hFF, 8'hFF},
        '{STEP_WRITE, REG_SHOWN_NUMBER, 14'd8,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd440,  10'd560,  8'h00, 8'hFF},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd460,  10'd570,  8'h33, 8'hFF},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd450,  10'd565,  8'h44, 8'hFF},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd445,  10'd565,  8'h44, 8'h44},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd445,  10'd540,  8'h10, 8'h00},
        '{STEP_WRITE, REG_SHOWN_NUMBER, 14'd1,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd440,  10'd560,  8'h55, 8'h55},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd445,  10'd570,  8'h00, 8'hFF},
        '{STEP_WRITE, REG_INK,          14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd455,  10'd570,  8'hAA, 8'h00},
        '{STEP_WRITE, REG_SEG_LEN,      14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_KNOWN, REG_SHOWN_NUMBER, 14'd0,     10'd441,  10'd561,  8'hAA, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd442,  10'd561,  8'hAA, 8'h00},
        '{STEP_WRITE, REG_SHOWN_NUMBER, 14'h3FFF,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_SEG_LEN,      14'h3FFF,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_DIGIT_PITCH,  14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_INK,          14'h3FFF,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd440,  10'd560,  8'h01, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd503,  10'd623,  8'h02, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd470,  10'd560,  8'h03, 8'h00},
        '{STEP_WRITE, REG_ANCHOR_ROW,   14'h3FFF,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_ANCHOR_COL,   14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_DIGIT_PITCH,  14'd127,   10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd1023, 10'd0,    8'h04, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd1023, 10'd63,   8'h05, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd1023, 10'd64,   8'h06, 8'h00},
        '{STEP_WRITE, REG_SPARE_6,      14'h3FFF,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_SPARE_7,      14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd1023, 10'd10,   8'h07, 8'h00},
        '{STEP_WRITE, REG_ANCHOR_ROW,   14'd0,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_ANCHOR_COL,   14'd1023,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_SHOWN_NUMBER, 14'd1234,  10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_SEG_LEN,      14'd5,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_WRITE, REG_DIGIT_PITCH,  14'd6,     10'd0,    10'd0,    8'h00, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd0,    10'd1023, 8'h08, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd5,    10'd1017, 8'h09, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd10,   10'd1005, 8'h0A, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd2,    10'd1011, 8'h0B, 8'h00},
        '{STEP_PIXEL, REG_SHOWN_NUMBER, 14'd0,     10'd0,    10'd1005, 8'h0C, 8'h00}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssno_pix_if pix_if ();
    ssno_res_if res_if ();

    seven_segment_number_overlay u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [NUM_W-1:0]   cur_number;
    logic [ROW_W-1:0]   cur_anchor_row;
    logic [COL_W-1:0]   cur_anchor_col;
    logic [LEN_W-1:0]   cur_seg_len;
    logic [PITCH_W-1:0] cur_digit_pitch;
    logic [PIX_W-1:0]   cur_ink;

    logic [PIX_W-1:0] pending_pixels [$];
    logic [PIX_W-1:0] want_pixel;
    int fail_count  = 0;
    int sent_count  = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    bit hold_done   = 1'b0;

    function automatic bit on_lit_segment(input int r, input int c, input int top,
                                          input int left, input int len,
                                          input seg_mask_t mask);
        int right;
        int mid;
        int bot;
        bit hit;
        right = left + len;
        mid   = top + len;
        bot   = top + 2 * len;
        hit   = 1'b0;
        if (mask[0] && r == top && c >= left && c <= right) hit = 1'b1;
        if (mask[1] && c == right && r >= top && r <= mid) hit = 1'b1;
        if (mask[2] && c == right && r >= mid && r <= bot) hit = 1'b1;
        if (mask[3] && r == bot && c >= left && c <= right) hit = 1'b1;
        if (mask[4] && c == left && r >= mid && r <= bot) hit = 1'b1;
        if (mask[5] && c == left && r >= top && r <= mid) hit = 1'b1;
        if (mask[6] && r == mid && c >= left && c <= right) hit = 1'b1;
        return hit;
    endfunction

    function automatic logic [PIX_W-1:0] overlay_pixel(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col,
                                                       input logic [PIX_W-1:0] px);
        int n;
        int d;
        int left;
        int len;
        bit lit;
        len = (cur_seg_len == 0) ? 1 : int'(cur_seg_len);
        n = int'(cur_number);
        if (n > int'(NUM_LIMIT)) n = int'(NUM_LIMIT);
        lit = 1'b0;
        for (int k = 0; k < DIGITS; k++) begin
            if (n != 0) begin
                d = n % 10;
                left = int'(cur_anchor_col) - k * int'(cur_digit_pitch);
                n = n / 10;
                if (on_lit_segment(int'(row), int'(col), int'(cur_anchor_row), left, len,
                                   DIGIT_SEGMENTS[d]))
                    lit = 1'b1;
            end
        end
        return lit ? cur_ink : px;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_SHOWN_NUMBER: cur_number      = data[NUM_W-1:0];
            REG_ANCHOR_ROW:   cur_anchor_row  = data[ROW_W-1:0];
            REG_ANCHOR_COL:   cur_anchor_col  = data[COL_W-1:0];
            REG_SEG_LEN:      cur_seg_len     = data[LEN_W-1:0];
            REG_DIGIT_PITCH:  cur_digit_pitch = data[PITCH_W-1:0];
            REG_INK:          cur_ink         = data[PIX_W-1:0];
            default: ;
        endcase
    endtask

    // valid stays high on return; the caller lowers it when the stream pauses
    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] want);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pix_row  <= row;
        pix_if.pix_col  <= col;
        pix_if.pixel_in <= px;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        pending_pixels.push_back(want);
        sent_count++;
    endtask

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: unexpected transaction, expected none, actual %0h",
                       res_if.pixel_out);
                fail_count++;
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (res_if.pixel_out !== want_pixel) begin
                    $error("pixel_out: expected %0h, actual %0h", want_pixel, res_if.pixel_out);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off so the pipeline fills
    initial begin
        int held;
        res_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                res_if.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin
        int r;
        int c;
        int len;
        int k;
        int top;
        int left;
        step_t st;
        logic [CFG_DATA_W-1:0] data;
        logic [ROW_W-1:0] prow;
        logic [COL_W-1:0] pcol;
        logic [PIX_W-1:0] ppix;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix_if.valid    = 1'b0;
        pix_if.pix_row  = '0;
        pix_if.pix_col  = '0;
        pix_if.pixel_in = '0;
        cur_number      = '0;
        cur_anchor_row  = ANCHOR_ROW_RST;
        cur_anchor_col  = ANCHOR_COL_RST;
        cur_seg_len     = SEG_LEN_RST;
        cur_digit_pitch = DIGIT_PITCH_RST;
        cur_ink         = INK_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_STEPS; i++) begin
            st = DIRECTED[i];
            if (st.kind == STEP_WRITE) begin
                pix_if.valid <= 1'b0;
                write_register(st.index, st.data);
            end else begin
                send_pixel(st.row, st.col, st.pixel,
                           (st.kind == STEP_KNOWN) ? st.known
                                                   : overlay_pixel(st.row, st.col, st.pixel));
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            pix_if.valid <= 1'b0;
            if (phase == PHASES - 1) quiet = 1'b1;

            case ($urandom_range(0, 5))
                0:       data = '0;
                1:       data = 14'd9999;
                2:       data = CFG_DATA_W'($urandom_range(10000, 16383));
                3:       data = CFG_DATA_W'($urandom_range(1, 99));
                default: data = CFG_DATA_W'($urandom_range(0, 9999));
            endcase
            write_register(REG_SHOWN_NUMBER, data);

            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 3))
                0:       data[ROW_W-1:0] = '0;
                1:       data[ROW_W-1:0] = '1;
                default: data[ROW_W-1:0] = ROW_W'($urandom_range(0, 900));
            endcase
            write_register(REG_ANCHOR_ROW, data);

            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 3))
                0:       data[COL_W-1:0] = '0;
                1:       data[COL_W-1:0] = '1;
                default: data[COL_W-1:0] = COL_W'($urandom_range(100, 1023));
            endcase
            write_register(REG_ANCHOR_COL, data);

            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 4))
                0:       data[LEN_W-1:0] = '0;
                1:       data[LEN_W-1:0] = '1;
                default: data[LEN_W-1:0] = LEN_W'($urandom_range(1, 16));
            endcase
            write_register(REG_SEG_LEN, data);

            data = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 4))
                0:       data[PITCH_W-1:0] = '0;
                1:       data[PITCH_W-1:0] = '1;
                default: data[PITCH_W-1:0] = PITCH_W'($urandom_range(1, 40));
            endcase
            write_register(REG_DIGIT_PITCH, data);

            write_register(REG_INK, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                               CFG_DATA_W'($urandom));

            for (int n = 0; n < PHASE_PIXELS; n++) begin
                len = (cur_seg_len == 0) ? 1 : int'(cur_seg_len);
                if ($urandom_range(0, 4) == 0) begin
                    prow = ROW_W'($urandom);
                    pcol = COL_W'($urandom);
                end else begin
                    // aim at the bars of a random digit cell
                    k    = $urandom_range(0, DIGITS - 1);
                    top  = int'(cur_anchor_row);
                    left = int'(cur_anchor_col) - k * int'(cur_digit_pitch);
                    if ($urandom_range(0, 1)) begin
                        r = top + int'($urandom_range(0, 2)) * len;
                        c = left + int'($urandom_range(0, len));
                    end else begin
                        r = top + int'($urandom_range(0, 2 * len));
                        c = left + int'($urandom_range(0, 1)) * len;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        r = r + int'($urandom_range(0, 2)) - 1;
                        c = c + int'($urandom_range(0, 2)) - 1;
                    end
                    prow = r[ROW_W-1:0];
                    pcol = c[COL_W-1:0];
                end
                ppix = PIX_W'($urandom);
                send_pixel(prow, pcol, ppix, overlay_pixel(prow, pcol, ppix));
            end
        end

        pix_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
